/* rtl/memory_lcd_frame_controller_assert.svh */
// Assertion macros for the memory LCD frame controller.
// MLCD_ASSERT_IMP: same-cycle implication. MLCD_ASSERT_NXT: next-cycle implication.
`ifndef MEMORY_LCD_FRAME_CONTROLLER_ASSERT_SVH
`define MEMORY_LCD_FRAME_CONTROLLER_ASSERT_SVH
`ifndef SYNTHESIS
`define MLCD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mlcd assertion failed");
`define MLCD_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mlcd assertion failed");
`else
`define MLCD_ASSERT_IMP(label, clk, rst, ante, cons)
`define MLCD_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/mlcd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package mlcd_pkg;

  localparam int WIDTH_PIXELS_DEF = 160;
  localparam int HEIGHT_LINES_DEF = 68;

  localparam int BC_W   = 6;
  localparam int LINE_W = 8;
  localparam int PROD_W = 14;
  localparam int STEP_W = 4;

  localparam logic [BC_W-1:0] BC_PENDING = 6'd63;

  localparam logic [7:0] CMDB_UPDATE = 8'h01;
  localparam logic [7:0] CMDB_CLEAR  = 8'h04;
  localparam logic [7:0] BYTE_WHITE  = 8'hFF;
  localparam logic [7:0] BYTE_ZERO   = 8'h00;

  typedef enum logic [2:0] {
    CMD_SET_PIXEL = 3'd0,
    CMD_REFRESH   = 3'd1,
    CMD_CLEAR     = 3'd2,
    CMD_FILL      = 3'd3,
    CMD_VCOM_ONLY = 3'd4,
    CMD_BYTE_TICK = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_IDLE    = 3'd0,
    KIND_REFRESH = 3'd1,
    KIND_CLEAR   = 3'd2,
    KIND_FILL    = 3'd3,
    KIND_VCOM    = 3'd4
  } kind_t;

  // Work class picked by the decode step
  typedef enum logic [1:0] {
    CLS_EMIT  = 2'd0,
    CLS_PIXEL = 2'd1,
    CLS_STORE = 2'd2,
    CLS_CLEAR = 2'd3
  } cls_t;

  typedef enum logic [2:0] {
    J_NEXT     = 3'd0,
    J_GOTO     = 3'd1,
    J_IN       = 3'd2,
    J_OUT      = 3'd3,
    J_CLR      = 3'd4,
    J_DISPATCH = 3'd5
  } jump_t;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_FETCH    = 4'd0;
  localparam step_t STEP_DECODE   = 4'd1;
  localparam step_t STEP_PIX_RD   = 4'd2;
  localparam step_t STEP_PIX_WR   = 4'd3;
  localparam step_t STEP_TICK_RD  = 4'd4;
  localparam step_t STEP_TICK_CAP = 4'd5;
  localparam step_t STEP_CLR      = 4'd6;
  localparam step_t STEP_EMIT     = 4'd7;
  localparam step_t STEP_RST_CLR  = 4'd8;

  typedef struct packed {
    logic accept;
    logic decode;
    logic mem_rd;
    logic pix_wr;
    logic cap_byte;
    logic clr_wr;
    logic emit;
  } ctrl_t;

  typedef struct packed {
    ctrl_t ctl;
    jump_t jmp;
    step_t target;
  } uword_t;

  typedef struct packed {
    logic in_fire;
    logic out_free;
    logic clr_done;
    cls_t cls;
  } seq_cond_t;

  // Microcode ROM
  function automatic uword_t ucode(input step_t step);
    uword_t w;
    w = '0;
    case (step)
      STEP_FETCH: begin
        w.ctl.accept = 1'b1;
        w.jmp = J_IN;
        w.target = STEP_DECODE;
      end
      STEP_DECODE: begin
        w.ctl.decode = 1'b1;
        w.jmp = J_DISPATCH;
        w.target = STEP_EMIT;
      end
      STEP_PIX_RD: begin
        w.ctl.mem_rd = 1'b1;
        w.jmp = J_NEXT;
        w.target = STEP_PIX_WR;
      end
      STEP_PIX_WR: begin
        w.ctl.pix_wr = 1'b1;
        w.jmp = J_GOTO;
        w.target = STEP_EMIT;
      end
      STEP_TICK_RD: begin
        w.ctl.mem_rd = 1'b1;
        w.jmp = J_NEXT;
        w.target = STEP_TICK_CAP;
      end
      STEP_TICK_CAP: begin
        w.ctl.cap_byte = 1'b1;
        w.jmp = J_GOTO;
        w.target = STEP_EMIT;
      end
      STEP_CLR: begin
        w.ctl.clr_wr = 1'b1;
        w.jmp = J_CLR;
        w.target = STEP_EMIT;
      end
      STEP_EMIT: begin
        w.ctl.emit = 1'b1;
        w.jmp = J_OUT;
        w.target = STEP_FETCH;
      end
      STEP_RST_CLR: begin
        w.ctl.clr_wr = 1'b1;
        w.jmp = J_CLR;
        w.target = STEP_FETCH;
      end
      default: begin
        w.jmp = J_GOTO;
        w.target = STEP_FETCH;
      end
    endcase
    return w;
  endfunction

  function automatic step_t dispatch_target(input cls_t cls);
    step_t s;
    case (cls)
      CLS_PIXEL: s = STEP_PIX_RD;
      CLS_STORE: s = STEP_TICK_RD;
      CLS_CLEAR: s = STEP_CLR;
      default:   s = STEP_EMIT;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

/* rtl/mlcd_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface mlcd_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] x;
  logic [7:0] y;
  logic       white;

  modport source (output valid, command, x, y, white, input ready);
  modport sink   (input valid, command, x, y, white, output ready);
endinterface

interface mlcd_rsp_if;
  logic       valid;
  logic       ready;
  logic       byte_valid;
  logic [7:0] tx_byte;
  logic       frame_active;
  logic       frame_last;
  logic       rejected;

  modport source (output valid, byte_valid, tx_byte, frame_active, frame_last, rejected,
                  input ready);
  modport sink   (input valid, byte_valid, tx_byte, frame_active, frame_last, rejected,
                  output ready);
endinterface
`default_nettype wire

/* rtl/memory_lcd_frame_controller.sv */
`timescale 1ns / 1ps
`default_nettype none
// Memory LCD frame controller.
// req (sink): one command per beat: set_pixel, refresh, clear, fill, vcom_only, byte_tick,
//   with pixel x, y and the white bit. A beat moves when valid and ready are both high.
// rsp (source): exactly one result beat per request beat, in order: byte_valid, tx_byte,
//   frame_active, frame_last, rejected.
// A microcoded step counter runs each request: fetch, decode, then optional frame-store
//   steps, then emit into the output register. The store is a single-port RAM with a
//   registered read, so a set_pixel (read, then write back) and a byte_tick that reads
//   the store add a read step and a write-back or capture step before emit; every other
//   command except clear goes from decode straight to emit.
// A clear command zeroes the store one byte per cycle, with ready low meanwhile.
// Reset (rst, synchronous) zeroes vcom and the frame state and runs the same clearing
//   pass, with ready low, before the first request is taken.
// When the receiver stalls, the result holds in the output register; the next request is
//   still accepted and decoded, and waits at the emit step until the register frees.
`include "memory_lcd_frame_controller_assert.svh"
module memory_lcd_frame_controller #(
  parameter int WIDTH_PIXELS = mlcd_pkg::WIDTH_PIXELS_DEF,
  parameter int HEIGHT_LINES = mlcd_pkg::HEIGHT_LINES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  mlcd_req_if.sink   req,
  mlcd_rsp_if.source rsp
);

  localparam int BPL         = (WIDTH_PIXELS + 7) / 8;
  localparam int STORE_BYTES = BPL * HEIGHT_LINES;
  localparam int AW          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

  localparam logic [mlcd_pkg::BC_W-1:0]   BPL_L    = mlcd_pkg::BC_W'(BPL);
  localparam logic [mlcd_pkg::LINE_W-1:0] HEIGHT_L = mlcd_pkg::LINE_W'(HEIGHT_LINES);
  localparam logic [8:0]                  WIDTH_L  = 9'(WIDTH_PIXELS);
  localparam logic [AW-1:0]               LAST_A   = AW'(STORE_BYTES - 1);

  // Control from the sequencer
  mlcd_pkg::ctrl_t     ctl;
  mlcd_pkg::seq_cond_t cond;
  mlcd_pkg::cls_t      cls;

  // Latched request
  logic [2:0] cmd_r;
  logic [7:0] x_r;
  logic [7:0] y_r;
  logic       white_r;

  // Frame state
  mlcd_pkg::kind_t             kind, kind_next;
  logic [mlcd_pkg::BC_W-1:0]   bc, bc_next;
  logic [mlcd_pkg::LINE_W-1:0] line, line_next;
  logic                        vcom, vcom_next;
  logic                        fill, fill_next;
  logic [AW-1:0]               addr, addr_next;
  logic [AW-1:0]               clr_addr;

  // Staged result
  logic       res_valid, d_valid;
  logic [7:0] res_byte, d_byte;
  logic       res_fa, d_fa;
  logic       res_last, d_last;
  logic       res_rej, d_rej;

  // Output register
  logic       out_valid;
  logic       out_bv;
  logic [7:0] out_byte;
  logic       out_fa;
  logic       out_last;
  logic       out_rej;
  logic       out_free;

  // Store
  logic [7:0]    store [STORE_BYTES];
  logic [7:0]    rd_data;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [7:0]    mem_wd;
  logic [7:0]    pix_mask;

  logic                         active;
  logic                         pix_in_range;
  logic [mlcd_pkg::PROD_W-1:0]  pix_mul;
  logic [mlcd_pkg::PROD_W-1:0]  line_mul;
  logic [AW-1:0]                pix_addr;
  logic [AW-1:0]                tick_addr;
  logic [7:0]                   vcom_bits;

  mlcd_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .cond (cond),
    .ctl  (ctl)
  );

  assign req.ready     = ctl.accept;
  assign out_free      = !out_valid || rsp.ready;
  assign cond.in_fire  = req.valid && ctl.accept;
  assign cond.out_free = out_free;
  assign cond.clr_done = (clr_addr == LAST_A);
  assign cond.cls      = cls;

  assign active       = (kind != mlcd_pkg::KIND_IDLE);
  assign pix_in_range = ({1'b0, x_r} < WIDTH_L) && (y_r < HEIGHT_L);
  assign pix_mul      = mlcd_pkg::PROD_W'(y_r) * mlcd_pkg::PROD_W'(BPL_L);
  assign line_mul     = mlcd_pkg::PROD_W'(line) * mlcd_pkg::PROD_W'(BPL_L);
  assign pix_addr     = AW'(pix_mul + mlcd_pkg::PROD_W'(x_r[7:3]));
  assign tick_addr    = AW'(line_mul + mlcd_pkg::PROD_W'(bc - 6'd1));
  assign vcom_bits    = {6'b0, vcom, 1'b0};
  assign pix_mask     = 8'd1 << x_r[2:0];

  // Latch the request beat
  always_ff @(posedge clk) begin
    if (cond.in_fire) begin
      cmd_r   <= req.command;
      x_r     <= req.x;
      y_r     <= req.y;
      white_r <= req.white;
    end
  end

  // Decode: work out the result and the frame state update for one request
  always_comb begin
    cls       = mlcd_pkg::CLS_EMIT;
    d_valid   = 1'b0;
    d_byte    = mlcd_pkg::BYTE_ZERO;
    d_fa      = active;
    d_last    = 1'b0;
    d_rej     = 1'b0;
    kind_next = kind;
    bc_next   = bc;
    line_next = line;
    vcom_next = vcom;
    fill_next = fill;
    addr_next = addr;
    case (cmd_r)
      mlcd_pkg::CMD_BYTE_TICK: begin
        if (active) begin
          d_valid = 1'b1;
          if (bc == mlcd_pkg::BC_PENDING) begin
            // Command byte opens the frame
            case (kind)
              mlcd_pkg::KIND_CLEAR: d_byte = mlcd_pkg::CMDB_CLEAR | vcom_bits;
              mlcd_pkg::KIND_VCOM:  d_byte = vcom_bits;
              default:              d_byte = mlcd_pkg::CMDB_UPDATE | vcom_bits;
            endcase
            bc_next   = '0;
            line_next = (kind == mlcd_pkg::KIND_REFRESH || kind == mlcd_pkg::KIND_FILL) ?
                        '0 : HEIGHT_L;
          end else if (line >= HEIGHT_L) begin
            // Trailer closes the frame and flips vcom
            d_last    = 1'b1;
            kind_next = mlcd_pkg::KIND_IDLE;
            vcom_next = ~vcom;
            line_next = '0;
            bc_next   = '0;
          end else if (bc == '0) begin
            d_byte  = line + 8'd1;
            bc_next = 6'd1;
          end else if (bc <= BPL_L) begin
            if (kind == mlcd_pkg::KIND_FILL) begin
              d_byte = fill ? mlcd_pkg::BYTE_WHITE : mlcd_pkg::BYTE_ZERO;
            end else begin
              cls       = mlcd_pkg::CLS_STORE;
              addr_next = tick_addr;
            end
            bc_next = bc + 6'd1;
          end else begin
            bc_next   = '0;
            line_next = line + 8'd1;
          end
        end
      end
      mlcd_pkg::CMD_SET_PIXEL: begin
        if (active) begin
          d_rej = 1'b1;
        end else if (pix_in_range) begin
          cls       = mlcd_pkg::CLS_PIXEL;
          addr_next = pix_addr;
        end
      end
      mlcd_pkg::CMD_REFRESH, mlcd_pkg::CMD_CLEAR, mlcd_pkg::CMD_FILL,
      mlcd_pkg::CMD_VCOM_ONLY: begin
        if (active) begin
          d_rej = 1'b1;
        end else begin
          case (cmd_r)
            mlcd_pkg::CMD_REFRESH: kind_next = mlcd_pkg::KIND_REFRESH;
            mlcd_pkg::CMD_CLEAR:   kind_next = mlcd_pkg::KIND_CLEAR;
            mlcd_pkg::CMD_FILL:    kind_next = mlcd_pkg::KIND_FILL;
            default:               kind_next = mlcd_pkg::KIND_VCOM;
          endcase
          bc_next   = mlcd_pkg::BC_PENDING;
          line_next = '0;
          d_fa      = 1'b1;
          if (cmd_r == mlcd_pkg::CMD_FILL) begin
            fill_next = white_r;
          end
          if (cmd_r == mlcd_pkg::CMD_CLEAR) begin
            cls = mlcd_pkg::CLS_CLEAR;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Frame state and staged result
  always_ff @(posedge clk) begin
    if (rst) begin
      kind <= mlcd_pkg::KIND_IDLE;
      bc   <= '0;
      line <= '0;
      vcom <= 1'b0;
      fill <= 1'b0;
    end else if (ctl.decode) begin
      kind <= kind_next;
      bc   <= bc_next;
      line <= line_next;
      vcom <= vcom_next;
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.decode) begin
      addr      <= addr_next;
      res_valid <= d_valid;
      res_byte  <= d_byte;
      res_fa    <= d_fa;
      res_last  <= d_last;
      res_rej   <= d_rej;
    end else if (ctl.cap_byte) begin
      res_byte <= rd_data;
    end
  end

  // Clearing sweep: one byte a cycle, wrap to zero when done
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (ctl.clr_wr) begin
      clr_addr <= cond.clr_done ? '0 : clr_addr + 1'b1;
    end
  end

  // Store port: one write, one registered read
  always_comb begin
    mem_we = ctl.pix_wr || ctl.clr_wr;
    mem_wa = ctl.clr_wr ? clr_addr : addr;
    if (ctl.clr_wr) begin
      mem_wd = mlcd_pkg::BYTE_ZERO;
    end else if (white_r) begin
      mem_wd = rd_data | pix_mask;
    end else begin
      mem_wd = rd_data & ~pix_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_wa] <= mem_wd;
    end
    if (ctl.mem_rd) begin
      rd_data <= store[addr];
    end
  end

  // Output register: load at emit once free, drop valid when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit && out_free) begin
      out_bv   <= res_valid;
      out_byte <= res_byte;
      out_fa   <= res_fa;
      out_last <= res_last;
      out_rej  <= res_rej;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.byte_valid   = out_bv;
  assign rsp.tx_byte      = out_byte;
  assign rsp.frame_active = out_fa;
  assign rsp.frame_last   = out_last;
  assign rsp.rejected     = out_rej;

  `MLCD_ASSERT_IMP(a_last_closes_frame, clk, rst, ctl.emit && out_free && res_last, !active)
  `MLCD_ASSERT_IMP(a_no_accept_in_sweep, clk, rst, ctl.clr_wr, !req.ready)
  `MLCD_ASSERT_IMP(a_reject_has_no_byte, clk, rst, rsp.valid && rsp.rejected, !rsp.byte_valid)
  `MLCD_ASSERT_NXT(a_clear_starts_sweep, clk, rst, ctl.decode && cls == mlcd_pkg::CLS_CLEAR, ctl.clr_wr)

endmodule
`default_nettype wire

/* rtl/mlcd_seq.sv */
`timescale 1ns / 1ps
`default_nettype none
module mlcd_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  mlcd_pkg::seq_cond_t  cond,
  output mlcd_pkg::ctrl_t      ctl
);

  mlcd_pkg::step_t  pc;
  mlcd_pkg::step_t  pc_next;
  mlcd_pkg::uword_t uw;

  assign uw  = mlcd_pkg::ucode(pc);
  assign ctl = uw.ctl;

  always_comb begin
    case (uw.jmp)
      mlcd_pkg::J_NEXT:     pc_next = pc + 4'd1;
      mlcd_pkg::J_GOTO:     pc_next = uw.target;
      mlcd_pkg::J_IN:       pc_next = cond.in_fire ? uw.target : pc;
      mlcd_pkg::J_OUT:      pc_next = cond.out_free ? uw.target : pc;
      mlcd_pkg::J_CLR:      pc_next = cond.clr_done ? uw.target : pc;
      mlcd_pkg::J_DISPATCH: pc_next = mlcd_pkg::dispatch_target(cond.cls);
      default:              pc_next = mlcd_pkg::STEP_FETCH;
    endcase
  end

  // Reset starts in the store-clearing loop
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= mlcd_pkg::STEP_RST_CLR;
    end else begin
      pc <= pc_next;
    end
  end

endmodule
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
module testbench;

  localparam int PANEL_W     = mlcd_pkg::WIDTH_PIXELS_DEF;
  localparam int PANEL_H     = mlcd_pkg::HEIGHT_LINES_DEF;
  localparam int LINE_BYTES  = (PANEL_W + 7) / 8;
  localparam int STORE_BYTES = LINE_BYTES * PANEL_H;

  // Cycles with no beat on either channel before the run is called hung. The worst
  // legal quiet spell is a clearing pass plus a receiver stall.
  localparam int STALL_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 20;
  localparam int MIX_ITEMS     = 80;
  localparam int FILL_TICKS    = 48;
  localparam int NOISE_PCT     = 3;
  localparam int SHOW_MAX      = 10;

  // Command codes that the block does not define.
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] tx_byte;
    logic       frame_active;
    logic       frame_last;
    logic       rejected;
  } lcd_beat_t;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] col;
    logic [7:0] row;
    logic       white;
    logic       typed;
    lcd_beat_t  beat;
  } stim_row_t;

  localparam lcd_beat_t B_IDLE    = '{1'b0, 8'h00, 1'b0, 1'b0, 1'b0};
  localparam lcd_beat_t B_OPEN    = '{1'b0, 8'h00, 1'b1, 1'b0, 1'b0};
  localparam lcd_beat_t B_REJ     = '{1'b0, 8'h00, 1'b1, 1'b0, 1'b1};
  localparam lcd_beat_t B_TRAILER = '{1'b1, 8'h00, 1'b1, 1'b1, 1'b0};

  // Directed opening: idle and spare commands, pixel extremes in and out of range,
  // commands refused during a frame, and the bytes of a vcom and a clear frame.
  localparam stim_row_t DIR_ROWS [20] = '{
    '{mlcd_pkg::CMD_BYTE_TICK, 8'd0,   8'd0,   1'b0, 1'b1, B_IDLE},
    '{CMD_SPARE_6,             8'd255, 8'd255, 1'b1, 1'b1, B_IDLE},
    '{CMD_SPARE_7,             8'd0,   8'd0,   1'b0, 1'b1, B_IDLE},
    '{mlcd_pkg::CMD_SET_PIXEL, 8'd0,   8'd0,   1'b1, 1'b0, B_IDLE},
    '{mlcd_pkg::CMD_SET_PIXEL, 8'd159, 8'd67,  1'b1, 1'b0, B_IDLE},
    '{mlcd_pkg::CMD_SET_PIXEL, 8'd160, 8'd0,   1'b1, 1'b1, B_IDLE},
    '{mlcd_pkg::CMD_SET_PIXEL, 8'd0,   8'd68,  1'b1, 1'b1, B_IDLE},
    '{mlcd_pkg::CMD_SET_PIXEL, 8'd255, 8'd255, 1'b1, 1'b1, B_IDLE},
    '{mlcd_pkg::CMD_VCOM_ONLY, 8'd0,   8'd0,   1'b0, 1'b1, B_OPEN},
    '{mlcd_pkg::CMD_REFRESH,   8'd0,   8'd0,   1'b0, 1'b1, B_REJ},
    '{mlcd_pkg::CMD_SET_PIXEL, 8'd1,   8'd1,   1'b1, 1'b1, B_REJ},
    '{CMD_SPARE_7,             8'd0,   8'd0,   1'b1, 1'b1, B_OPEN},
    '{mlcd_pkg::CMD_BYTE_TICK, 8'd0,   8'd0,   1'b0, 1'b1, '{1'b1, 8'h00, 1'b1, 1'b0, 1'b0}},
    '{mlcd_pkg::CMD_BYTE_TICK, 8'd0,   8'd0,   1'b0, 1'b1, B_TRAILER},
    '{mlcd_pkg::CMD_BYTE_TICK, 8'd0,   8'd0,   1'b0, 1'b1, B_IDLE},
    '{mlcd_pkg::CMD_CLEAR,     8'd0,   8'd0,   1'b1, 1'b1, B_OPEN},
    '{mlcd_pkg::CMD_BYTE_TICK, 8'd0,   8'd0,   1'b0, 1'b1, '{1'b1, 8'h06, 1'b1, 1'b0, 1'b0}},
    '{mlcd_pkg::CMD_BYTE_TICK, 8'd0,   8'd0,   1'b0, 1'b1, B_TRAILER},
    '{mlcd_pkg::CMD_SET_PIXEL, 8'd7,   8'd0,   1'b1, 1'b0, B_IDLE},
    '{mlcd_pkg::CMD_SET_PIXEL, 8'd159, 8'd0,   1'b1, 1'b0, B_IDLE}
  };

  logic clk;
  logic rst;

  mlcd_req_if req_bus ();
  mlcd_rsp_if rsp_bus ();

  memory_lcd_frame_controller #(
    .WIDTH_PIXELS (PANEL_W),
    .HEIGHT_LINES (PANEL_H)
  ) u_top (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  // Panel mirror: pixel store, vcom phase and frame position.
  logic [7:0]      pix_store [0:STORE_BYTES-1];
  logic            vcom_bit;
  mlcd_pkg::kind_t cur_kind;
  int              line_idx;
  int              pos_in_line;
  logic            fill_white;

  lcd_beat_t  expected_beats [$];
  logic       row_typed;
  lcd_beat_t  row_beat;
  lcd_beat_t  want;
  lcd_beat_t  got;

  int burst_left;
  int idle_cycles;
  int errors;
  int req_beats;
  int frame_bytes;
  int frames_closed;
  int refusals;
  int pix_hits;
  int pix_misses;

  // Advance the mirror by one request beat and return the result beat it implies.
  function automatic lcd_beat_t predict_beat(input logic [2:0] op, input logic [7:0] col,
                                             input logic [7:0] row, input logic w);
    lcd_beat_t  r;
    logic       busy;
    logic [7:0] vc;
    int         addr;
    r    = '0;
    busy = (cur_kind != mlcd_pkg::KIND_IDLE);
    vc   = {6'b0, vcom_bit, 1'b0};
    r.frame_active = busy;
    if (op == mlcd_pkg::CMD_BYTE_TICK) begin
      if (busy) begin
        r.byte_valid = 1'b1;
        frame_bytes++;
        if (pos_in_line == int'(mlcd_pkg::BC_PENDING)) begin
          case (cur_kind)
            mlcd_pkg::KIND_CLEAR: r.tx_byte = mlcd_pkg::CMDB_CLEAR | vc;
            mlcd_pkg::KIND_VCOM:  r.tx_byte = vc;
            default:              r.tx_byte = mlcd_pkg::CMDB_UPDATE | vc;
          endcase
          pos_in_line = 0;
          line_idx = (cur_kind == mlcd_pkg::KIND_REFRESH ||
                      cur_kind == mlcd_pkg::KIND_FILL) ? 0 : PANEL_H;
        end else if (line_idx >= PANEL_H) begin
          // trailer closes the frame and flips vcom
          r.tx_byte    = mlcd_pkg::BYTE_ZERO;
          r.frame_last = 1'b1;
          cur_kind     = mlcd_pkg::KIND_IDLE;
          vcom_bit     = ~vcom_bit;
          line_idx     = 0;
          pos_in_line  = 0;
          frames_closed++;
        end else if (pos_in_line == 0) begin
          r.tx_byte   = 8'(line_idx + 1);
          pos_in_line = 1;
        end else if (pos_in_line <= LINE_BYTES) begin
          if (cur_kind == mlcd_pkg::KIND_FILL)
            r.tx_byte = fill_white ? mlcd_pkg::BYTE_WHITE : mlcd_pkg::BYTE_ZERO;
          else
            r.tx_byte = pix_store[line_idx * LINE_BYTES + pos_in_line - 1];
          pos_in_line++;
        end else begin
          r.tx_byte   = mlcd_pkg::BYTE_ZERO;
          pos_in_line = 0;
          line_idx++;
        end
      end
    end else if (op <= mlcd_pkg::CMD_VCOM_ONLY) begin
      if (busy) begin
        r.rejected = 1'b1;
        refusals++;
      end else if (op == mlcd_pkg::CMD_SET_PIXEL) begin
        if (int'(col) < PANEL_W && int'(row) < PANEL_H) begin
          addr = int'(row) * LINE_BYTES + int'(col) / 8;
          pix_store[addr][col[2:0]] = w;
          pix_hits++;
        end else begin
          pix_misses++;
        end
      end else begin
        cur_kind    = mlcd_pkg::kind_t'(op);
        pos_in_line = int'(mlcd_pkg::BC_PENDING);
        line_idx    = 0;
        if (op == mlcd_pkg::CMD_FILL) fill_white = w;
        if (op == mlcd_pkg::CMD_CLEAR) begin
          for (int i = 0; i < STORE_BYTES; i++) pix_store[i] = '0;
        end
        r.frame_active = 1'b1;
      end
    end
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Predict on every accepted request, check every accepted result, watch for a hang.
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STORE_BYTES; i++) pix_store[i] = '0;
      vcom_bit    = 1'b0;
      cur_kind    = mlcd_pkg::KIND_IDLE;
      line_idx    = 0;
      pos_in_line = 0;
      fill_white  = 1'b0;
      expected_beats.delete();
      idle_cycles = 0;
    end else begin
      if (req_bus.valid && req_bus.ready) begin
        want = predict_beat(req_bus.command, req_bus.x, req_bus.y, req_bus.white);
        if (row_typed) want = row_beat;
        expected_beats.push_back(want);
        req_beats++;
      end
      if (rsp_bus.valid && rsp_bus.ready) begin
        got = {rsp_bus.byte_valid, rsp_bus.tx_byte, rsp_bus.frame_active,
               rsp_bus.frame_last, rsp_bus.rejected};
        if (expected_beats.size() == 0) begin
          errors++;
          if (errors <= SHOW_MAX)
            $display("%0t: unexpected result: valid=%b byte=%h act=%b last=%b rej=%b",
                     $realtime, got.byte_valid, got.tx_byte, got.frame_active,
                     got.frame_last, got.rejected);
        end else begin
          want = expected_beats.pop_front();
          if (got.byte_valid !== want.byte_valid || got.tx_byte !== want.tx_byte ||
              got.frame_active !== want.frame_active || got.frame_last !== want.frame_last ||
              got.rejected !== want.rejected) begin
            errors++;
            if (errors <= SHOW_MAX) begin
              $display("%0t: result differs: exp valid=%b byte=%h act=%b last=%b rej=%b",
                       $realtime, want.byte_valid, want.tx_byte, want.frame_active,
                       want.frame_last, want.rejected);
              $display("%0t:                 got valid=%b byte=%h act=%b last=%b rej=%b",
                       $realtime, got.byte_valid, got.tx_byte, got.frame_active,
                       got.frame_last, got.rejected);
            end
          end
        end
      end
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Hang: no beat for %0d cycles, %0d results pending",
                 idle_cycles, expected_beats.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Receiver: segments of steady flow, light or heavy random stalls, and long holds.
  initial begin
    int span;
    int hold;
    int run;
    int stall_pct;
    rsp_bus.ready = 1'b0;
    @(negedge clk);
    forever begin
      span = $urandom_range(20, 200);
      if ($urandom_range(0, 3) == 0) begin
        while (span > 0) begin
          hold = $urandom_range(1, 12);
          rsp_bus.ready <= 1'b0;
          repeat (hold) @(negedge clk);
          run = $urandom_range(1, 6);
          rsp_bus.ready <= 1'b1;
          repeat (run) @(negedge clk);
          span -= hold + run;
        end
      end else begin
        stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 60);
        repeat (span) begin
          rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
          @(negedge clk);
        end
      end
    end
  end

  // Present one request beat and hold it until taken; sometimes open a gap between bursts.
  task automatic send_beat(input logic [2:0] op, input logic [7:0] col, input logic [7:0] row,
                           input logic w, input logic typed, input lcd_beat_t typed_beat);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        req_bus.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 300)
                                               : $urandom_range(1, 25);
    end
    req_bus.valid   <= 1'b1;
    req_bus.command <= op;
    req_bus.x       <= col;
    req_bus.y       <= row;
    req_bus.white   <= w;
    row_typed       <= typed;
    row_beat        <= typed_beat;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  // Drop valid and hold off until every pending result has come back.
  task automatic drain_results();
    req_bus.valid <= 1'b0;
    do @(negedge clk); while (expected_beats.size() != 0);
  endtask

  // Mostly ticks; now and then a random command code, refused unless it is a tick or a spare code.
  task automatic send_frame_beat();
    logic [2:0] op;
    if ($urandom_range(0, 99) < NOISE_PCT)
      op = 3'($urandom_range(0, 7));
    else
      op = mlcd_pkg::CMD_BYTE_TICK;
    send_beat(op, 8'($urandom), 8'($urandom), 1'($urandom), 1'b0, B_IDLE);
  endtask

  initial begin
    int         n;
    int         mixed;
    bit         refreshed;
    logic [2:0] op;
    logic [7:0] col;
    logic [7:0] row;
    rst             = 1'b1;
    req_bus.valid   = 1'b0;
    req_bus.command = mlcd_pkg::CMD_SET_PIXEL;
    req_bus.x       = '0;
    req_bus.y       = '0;
    req_bus.white   = 1'b0;
    row_typed       = 1'b0;
    row_beat        = B_IDLE;
    burst_left      = 0;
    errors          = 0;
    req_beats       = 0;
    frame_bytes     = 0;
    frames_closed   = 0;
    refusals        = 0;
    pix_hits        = 0;
    pix_misses      = 0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    foreach (DIR_ROWS[i])
      send_beat(DIR_ROWS[i].op, DIR_ROWS[i].col, DIR_ROWS[i].row, DIR_ROWS[i].white,
                DIR_ROWS[i].typed, DIR_ROWS[i].beat);

    // Random part: mix pixel writes with short frames and noise, then run one full
    // refresh so the pixel pattern is read back, then walk the head of a white fill.
    mixed     = 0;
    refreshed = 0;
    while (!refreshed || cur_kind != mlcd_pkg::KIND_IDLE) begin
      if (cur_kind != mlcd_pkg::KIND_IDLE) begin
        send_frame_beat();
      end else if (mixed < MIX_ITEMS) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: begin
            n = $urandom_range(5, 30);
            repeat (n) begin
              if ($urandom_range(0, 4) == 0) begin
                col = 8'($urandom);
                row = 8'($urandom);
              end else begin
                col = ($urandom_range(0, 7) == 0) ? 8'(PANEL_W - 1)
                                                  : 8'($urandom_range(0, PANEL_W - 1));
                row = ($urandom_range(0, 7) == 0) ? 8'(PANEL_H - 1)
                                                  : 8'($urandom_range(0, PANEL_H - 1));
              end
              send_beat(mlcd_pkg::CMD_SET_PIXEL, col, row, 1'($urandom), 1'b0, B_IDLE);
            end
            mixed += n;
          end
          5, 6: begin
            op = ($urandom_range(0, 3) == 0) ? mlcd_pkg::CMD_CLEAR : mlcd_pkg::CMD_VCOM_ONLY;
            send_beat(op, 8'($urandom), 8'($urandom), 1'($urandom), 1'b0, B_IDLE);
            mixed++;
          end
          8: drain_results();
          default: begin
            // idle noise: ticks, spare codes and raw pixel writes
            n = $urandom_range(1, 6);
            repeat (n) begin
              case ($urandom_range(0, 3))
                0:       op = mlcd_pkg::CMD_SET_PIXEL;
                1:       op = mlcd_pkg::CMD_BYTE_TICK;
                2:       op = CMD_SPARE_6;
                default: op = CMD_SPARE_7;
              endcase
              send_beat(op, 8'($urandom), 8'($urandom), 1'($urandom), 1'b0, B_IDLE);
            end
            mixed += n;
          end
        endcase
      end else begin
        drain_results();
        send_beat(mlcd_pkg::CMD_REFRESH, 8'($urandom), 8'($urandom), 1'($urandom), 1'b0,
                  B_IDLE);
        refreshed = 1;
      end
    end

    // The fill frame is left open at the end of the run.
    send_beat(mlcd_pkg::CMD_FILL, 8'($urandom), 8'($urandom), 1'b1, 1'b0, B_IDLE);
    repeat (FILL_TICKS) send_frame_beat();

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("Covered %0d request beats: %0d frame bytes, %0d closed frames, %0d refusals",
             req_beats, frame_bytes, frames_closed, refusals);
    $display("Pixel writes: %0d on panel, %0d off panel; %0d result errors",
             pix_hits, pix_misses, errors);
    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

/* memory_lcd_frame_controller.f */
+incdir+rtl
rtl/mlcd_pkg.sv
rtl/mlcd_if.sv
rtl/mlcd_seq.sv
rtl/memory_lcd_frame_controller.sv
tb/testbench.sv
